/* rtl/core/utf8_byte_stream_decoder_core_macros.svh */
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define UBSD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubsd assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define UBSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubsd assertion failed");

`endif

/* rtl/core/ubsd_pkg.sv */
// Types and constants for the UTF-8 byte stream decoder.
`default_nettype none

package ubsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [7:0]  ASCII_LIMIT    = 8'h80;
    localparam logic [7:0]  LEAD2_MASK     = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE     = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE     = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK     = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE     = 8'hF0;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_CODE      = 8'h80;

    // Input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       flush;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic [20:0] code_point;
        logic        is_replacement;
        logic        last;
    } out_item_t;

    // All results of one input item: reps replacements, then an optional tail
    typedef struct packed {
        logic [1:0]  reps;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic        tail_repl;
    } bundle_t;

endpackage

`default_nettype wire

/* rtl/core/utf8_byte_stream_decoder_core.sv */
// Top level of the UTF-8 byte stream decoder.
//
// Usage: the item channel carries one raw byte (or a flush marker) per
// transaction on item/item_valid/item_stall; the result channel carries one
// decoded code point per transaction on result/result_valid/result_stall.
// A transaction completes on a rising edge with valid high and stall low.
// Each item yields zero to four results; the final one of an item has last set.
// Throughput: one item per cycle while the results keep up; the output gives
// at most one result per cycle, and that bounds the sustained pace.
// With an empty queue the first result of an item goes through the input
// register, then decode into the bundle queue, then the output register.
// An item's results are queued as one bundle in a QUEUE_DEPTH-entry queue
// and serialized one per cycle unless the output is stalled; item_stall rises
// while the queue plus the item in decode could fill it. Items that give
// several results each, or result_stall holding the output back, fill the
// queue and stall the input.
// While result_stall is high the output register keeps its transaction.
// Reset clears the held sequence, the queue and the output valid at once.
`default_nettype none

module utf8_byte_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = ubsd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ubsd_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output ubsd_pkg::out_item_t result
);
    import ubsd_pkg::*;

    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    logic             pending;
    logic             push;
    bundle_t          push_bundle;
    logic [LVL_W-1:0] level;
    logic [LVL_W:0]   committed;

    // Room check covers the item still in decode
    assign committed  = {1'b0, level} + {{LVL_W{1'b0}}, pending};
    assign item_stall = committed >= (LVL_W + 1)'(QUEUE_DEPTH);
    assign accept     = item_valid && !item_stall;

    ubsd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_item     (item),
        .pending     (pending),
        .push        (push),
        .push_bundle (push_bundle)
    );

    ubsd_drain #(
        .DEPTH (QUEUE_DEPTH),
        .LVL_W (LVL_W)
    ) u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_bundle  (push_bundle),
        .level        (level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/core/ubsd_decode.sv */
// Input register, decode state and per-item result bundle generation.
`default_nettype none

`include "utf8_byte_stream_decoder_core_macros.svh"

module ubsd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ubsd_pkg::in_item_t in_item,
    output logic               pending,
    output logic               push,
    output ubsd_pkg::bundle_t  push_bundle
);
    import ubsd_pkg::*;

    typedef struct packed {
        logic        hold;
        logic [2:0]  exp_len;
        logic [20:0] value;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic        tail_repl;
    } fresh_t;

    // Decode a byte with nothing held
    function automatic fresh_t decode_fresh(input logic [7:0] b);
        fresh_t f;
        f = '0;
        if (b < ASCII_LIMIT) begin
            f.has_tail = 1'b1;
            f.tail_cp  = {13'd0, b};
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            f.hold    = 1'b1;
            f.exp_len = 3'd2;
            f.value   = {16'd0, b[4:0]};
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            f.hold    = 1'b1;
            f.exp_len = 3'd3;
            f.value   = {17'd0, b[3:0]};
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            f.hold    = 1'b1;
            f.exp_len = 3'd4;
            f.value   = {18'd0, b[2:0]};
        end else begin
            f.has_tail  = 1'b1;
            f.tail_cp   = REPLACEMENT_CP;
            f.tail_repl = 1'b1;
        end
        return f;
    endfunction

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic [1:0]  held_count_reg, held_count_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [20:0] value_reg, value_next;

    fresh_t      fresh;
    logic [2:0]  count_inc;
    logic [20:0] value_cont;

    assign pending    = in_valid_reg;
    assign fresh      = decode_fresh(in_item_reg.in_byte);
    assign count_inc  = {1'b0, held_count_reg} + 3'd1;
    assign value_cont = {value_reg[14:0], in_item_reg.in_byte[5:0]};

    // Decode against the held sequence
    always_comb begin
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        value_next      = value_reg;
        push_bundle     = '0;
        if (in_valid_reg) begin
            if (in_item_reg.flush) begin
                push_bundle.reps = held_count_reg;
                held_count_next  = '0;
                exp_len_next     = '0;
                value_next       = '0;
            end else if (held_count_reg != 2'd0 &&
                         (in_item_reg.in_byte & CONT_MASK) == CONT_CODE) begin
                if (count_inc >= exp_len_reg) begin
                    push_bundle.has_tail = 1'b1;
                    push_bundle.tail_cp  = value_cont;
                    held_count_next      = '0;
                    exp_len_next         = '0;
                    value_next           = '0;
                end else begin
                    held_count_next = count_inc[1:0];
                    value_next      = value_cont;
                end
            end else begin
                // Broken or empty sequence: release held bytes, restart on this byte
                push_bundle.reps      = held_count_reg;
                push_bundle.has_tail  = fresh.has_tail;
                push_bundle.tail_cp   = fresh.tail_cp;
                push_bundle.tail_repl = fresh.tail_repl;
                held_count_next       = fresh.hold ? 2'd1 : 2'd0;
                exp_len_next          = fresh.exp_len;
                value_next            = fresh.value;
            end
        end
    end

    assign push = in_valid_reg && (push_bundle.has_tail || push_bundle.reps != 2'd0);

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            held_count_reg <= '0;
            exp_len_reg    <= '0;
            value_reg      <= '0;
        end else begin
            in_valid_reg   <= accept;
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
            value_reg      <= value_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk) begin
        if (accept) begin
            in_item_reg <= in_item;
        end
    end

    `UBSD_ASSERT_IMPL(a_idle_no_len, held_count_reg == 2'd0, exp_len_reg == 3'd0)
    `UBSD_ASSERT_IMPL(a_held_short, held_count_reg != 2'd0, {1'b0, held_count_reg} < exp_len_reg)
    `UBSD_ASSERT_NEXT(a_push_follows_accept, !accept, !push)

endmodule

`default_nettype wire

/* rtl/core/ubsd_drain.sv */
// Result bundle queue and serializer feeding the output register.
`default_nettype none

`include "utf8_byte_stream_decoder_core_macros.svh"

module ubsd_drain #(
    parameter int unsigned DEPTH = ubsd_pkg::QUEUE_DEPTH,
    parameter int unsigned LVL_W = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ubsd_pkg::bundle_t    push_bundle,
    output logic [LVL_W-1:0]     level,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ubsd_pkg::out_item_t  result
);
    import ubsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bundle_t          q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic [1:0]       emitted_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    bundle_t          head;
    logic [2:0]       head_total;
    logic             is_last;
    logic             load;
    logic             pop;
    out_item_t        cur;

    assign head       = q_mem[rd_ptr_reg];
    assign head_total = {1'b0, head.reps} + {2'b00, head.has_tail};
    assign is_last    = ({1'b0, emitted_reg} + 3'd1) == head_total;
    assign load       = (level_reg != '0) && (!out_valid_reg || !result_stall);
    assign pop        = load && is_last;

    // Pick the next result of the head bundle
    always_comb begin
        if (emitted_reg < head.reps) begin
            cur.code_point     = REPLACEMENT_CP;
            cur.is_replacement = 1'b1;
        end else begin
            cur.code_point     = head.tail_cp;
            cur.is_replacement = head.tail_repl;
        end
        cur.last = is_last;
    end

    // Queue pointers, level, serializer position and output valid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            level_reg     <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + LVL_W'(1);
            end else if (pop && !push) begin
                level_reg <= level_reg - LVL_W'(1);
            end
            if (pop) begin
                emitted_reg <= '0;
            end else if (load) begin
                emitted_reg <= emitted_reg + 2'd1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Queue storage and output payload
    always_ff @(posedge clk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_bundle;
        end
        if (load) begin
            out_item_reg <= cur;
        end
    end

    assign level        = level_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    `UBSD_ASSERT_IMPL(a_no_overflow, push && !pop, level_reg < LVL_W'(DEPTH))
    `UBSD_ASSERT_IMPL(a_emit_in_range, level_reg != '0, {1'b0, emitted_reg} < head_total)
    `UBSD_ASSERT_IMPL(a_empty_at_start, level_reg == '0, emitted_reg == 2'd0)

endmodule

`default_nettype wire

/* tb/sv/utf8_byte_stream_decoder_core_test.sv */
// Self-checking testbench for the UTF-8 byte stream decoder core.
module utf8_byte_stream_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ubsd_pkg::*;

    localparam int unsigned RANDOM_ITEMS_PER_PHASE = 106;
    localparam int unsigned TAIL_CYCLES            = 8;

    // One directed row: the byte or flush to send and, when typed is set,
    // the results it must give (reps replacements, then an optional tail).
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        flush;
        logic        typed;
        logic [1:0]  reps;
        logic        tail;
        logic [20:0] tail_cp;
        logic        tail_repl;
    } stim_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // Decoder state mirrored by the predictor
    logic [2:0]  seq_held  = '0;
    logic [2:0]  seq_len   = '0;
    logic [20:0] seq_value = '0;

    out_item_t step_points[$];
    out_item_t pending_code_points[$];
    in_item_t  burst_bytes[$];

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned points_seen  = 0;
    int unsigned repl_seen    = 0;

    // Directed stimulus: extremes, invalid leads, every sequence length,
    // broken sequences and flushes
    stim_row_t dir_rows [0:25] = '{
        '{8'h00, 1'b0, 1'b1, 2'd0, 1'b1, 21'h000000,     1'b0},
        '{8'h7F, 1'b0, 1'b1, 2'd0, 1'b1, 21'h00007F,     1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, 1'b0, 21'h000000,     1'b0},
        '{8'hFF, 1'b0, 1'b1, 2'd1, 1'b0, 21'h000000,     1'b0},
        '{8'hF8, 1'b0, 1'b1, 2'd1, 1'b0, 21'h000000,     1'b0},
        '{8'hFF, 1'b1, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hC2, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hA9, 1'b0, 1'b1, 2'd0, 1'b1, 21'h0000A9,     1'b0},
        '{8'hEF, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hBD, 1'b0, 1'b1, 2'd0, 1'b1, REPLACEMENT_CP, 1'b0},
        '{8'hF7, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd0, 1'b1, 21'h1FFFFF,     1'b0},
        '{8'hF0, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'h90, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'h80, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd3, 1'b1, 21'h000041,     1'b0},
        '{8'hE2, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hC3, 1'b0, 1'b1, 2'd1, 1'b0, 21'h000000,     1'b0},
        '{8'h28, 1'b0, 1'b1, 2'd1, 1'b1, 21'h000028,     1'b0},
        '{8'hF4, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'hFF, 1'b0, 1'b1, 2'd2, 1'b0, 21'h000000,     1'b0},
        '{8'hE0, 1'b0, 1'b0, 2'd0, 1'b0, 21'h000000,     1'b0},
        '{8'h00, 1'b1, 1'b1, 2'd1, 1'b0, 21'h000000,     1'b0}
    };

    utf8_byte_stream_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void emit_point(input logic [20:0] cp, input logic repl);
        out_item_t pt;
        pt.code_point     = cp;
        pt.is_replacement = repl;
        pt.last           = 1'b0;
        step_points.insert(step_points.size(), pt);
    endfunction

    function automatic void drop_sequence();
        seq_held  = '0;
        seq_len   = '0;
        seq_value = '0;
    endfunction

    // One replacement per held byte, lead included
    function automatic void release_held();
        for (int i = 0; i < seq_held; i++)
            emit_point(REPLACEMENT_CP, 1'b1);
        drop_sequence();
    endfunction

    // Byte seen with nothing held
    function automatic void start_fresh(input logic [7:0] b);
        if (b < ASCII_LIMIT)
            emit_point({13'd0, b}, 1'b0);
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            seq_held  = 3'd1;
            seq_len   = 3'd2;
            seq_value = 21'(b & ~LEAD2_MASK);
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            seq_held  = 3'd1;
            seq_len   = 3'd3;
            seq_value = 21'(b & ~LEAD3_MASK);
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            seq_held  = 3'd1;
            seq_len   = 3'd4;
            seq_value = 21'(b & ~LEAD4_MASK);
        end
        else
            emit_point(REPLACEMENT_CP, 1'b1);
    endfunction

    // Results of one accepted transaction land in step_points
    function automatic void utf8_decode_item(input in_item_t it);
        step_points.delete();
        if (it.flush)
            release_held();
        else if (seq_held == 0)
            start_fresh(it.in_byte);
        else if ((it.in_byte & CONT_MASK) == CONT_CODE)
        begin
            seq_value = {seq_value[14:0], it.in_byte[5:0]};
            seq_held  = seq_held + 3'd1;
            if (seq_held >= seq_len)
            begin
                emit_point(seq_value, 1'b0);
                drop_sequence();
            end
        end
        else
        begin
            release_held();
            start_fresh(it.in_byte);
        end
        if (step_points.size() > 0)
            step_points[step_points.size() - 1].last = 1'b1;
    endfunction

    // Queue one result expectation for the checker
    function automatic void expect_point(input out_item_t pt);
        pending_code_points.insert(pending_code_points.size(), pt);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic in_item_t byte_item(input logic [7:0] b, input logic fl);
        in_item_t it;
        it.in_byte = b;
        it.flush   = fl;
        return it;
    endfunction

    function automatic void add_to_burst(input logic [7:0] b, input logic fl);
        burst_bytes.insert(burst_bytes.size(), byte_item(b, fl));
    endfunction

    function automatic logic [7:0] pick_lead(input int unsigned len);
        unique case (len)
            1:       return 8'($urandom_range(8'h7F, 8'h00));
            2:       return 8'($urandom_range(8'hDF, 8'hC0));
            3:       return 8'($urandom_range(8'hEF, 8'hE0));
            default: return 8'($urandom_range(8'hF7, 8'hF0));
        endcase
    endfunction

    function automatic logic [7:0] pick_cont();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    // Mostly well-formed sequences; the rest broken sequences, flushes, noise
    function automatic void build_burst();
        int unsigned pick;
        int unsigned len;
        int unsigned kept;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            len = $urandom_range(4, 1);
            add_to_burst(pick_lead(len), 1'b0);
            for (int i = 1; i < len; i++)
                add_to_burst(pick_cont(), 1'b0);
        end
        else if (pick < 82)
        begin
            len  = $urandom_range(4, 2);
            kept = $urandom_range(len - 2, 0);
            add_to_burst(pick_lead(len), 1'b0);
            for (int i = 0; i < kept; i++)
                add_to_burst(pick_cont(), 1'b0);
            b = 8'($urandom);
            if ($urandom_range(3) == 0)
                add_to_burst(b, 1'b1);
            else
            begin
                // anything but a continuation breaks the sequence
                if ((b & CONT_MASK) == CONT_CODE)
                    b[6] = 1'b1;
                add_to_burst(b, 1'b0);
            end
        end
        else if (pick < 90)
            add_to_burst(8'($urandom), 1'b1);
        else
            add_to_burst(8'($urandom), 1'b0);
    endfunction

    // Present one transaction, wait for acceptance, then run the predictor
    task automatic send_item(input in_item_t it, input bit from_model);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        utf8_decode_item(it);
        if (from_model)
            foreach (step_points[i])
                expect_point(step_points[i]);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_code_points.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- output side ----------------

    // Random backpressure on the result channel
    always @(posedge clk)
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            points_seen++;
            if (result.is_replacement)
                repl_seen++;
            if (pending_code_points.size() == 0)
            begin
                $error("unexpected result: code_point %h is_replacement %b last %b",
                       result.code_point, result.is_replacement, result.last);
                fail_count++;
            end
            else
            begin
                want = pending_code_points.pop_front();
                if (result.code_point !== want.code_point)
                begin
                    $error("code_point: expected %h, actual %h",
                           want.code_point, result.code_point);
                    fail_count++;
                end
                if (result.is_replacement !== want.is_replacement)
                begin
                    $error("is_replacement: expected %b, actual %b",
                           want.is_replacement, result.is_replacement);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        out_item_t   typed_pts[$];
        out_item_t   pt;
        stim_row_t   row;
        int unsigned phase_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(byte_item(row.in_byte, row.flush), !row.typed);
            if (row.typed)
            begin
                typed_pts.delete();
                for (int r = 0; r < row.reps; r++)
                begin
                    pt.code_point     = REPLACEMENT_CP;
                    pt.is_replacement = 1'b1;
                    pt.last           = 1'b0;
                    typed_pts.insert(typed_pts.size(), pt);
                end
                if (row.tail)
                begin
                    pt.code_point     = row.tail_cp;
                    pt.is_replacement = row.tail_repl;
                    pt.last           = 1'b0;
                    typed_pts.insert(typed_pts.size(), pt);
                end
                if (typed_pts.size() > 0)
                    typed_pts[typed_pts.size() - 1].last = 1'b1;
                foreach (typed_pts[k])
                    expect_point(typed_pts[k]);
            end
        end
        // sender holds off until every expected result is back
        wait_drained();

        // Random phases: no idling, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 56; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 56; end
                default: begin send_gap_pct = 12; stall_pct = 12; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS_PER_PHASE)
            begin
                build_burst();
                while (burst_bytes.size() != 0)
                    send_item(burst_bytes.pop_front(), 1'b1);
            end
            if (ph == 1)
                wait_drained();
        end

        item_valid <= 1'b0;
        while (pending_code_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d byte/flush transactions under four idle/stall mixes;",
                 items_sent);
        $display("checked %0d code points, %0d of them replacements, %0d mismatches.",
                 points_seen, repl_seen, fail_count);
        if (fail_count == 0)
            $display("utf8_byte_stream_decoder_core regression: pass");
        else
            $display("utf8_byte_stream_decoder_core regression: fail");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("utf8_byte_stream_decoder_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ubsd_pkg.sv
rtl/core/ubsd_decode.sv
rtl/core/ubsd_drain.sv
rtl/core/utf8_byte_stream_decoder_core.sv
tb/sv/utf8_byte_stream_decoder_core_test.sv
